>>> src/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package deq_pkg;

   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 7;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_DROP_FRONT = 3'd2;
   localparam logic [OP_W-1:0] OP_DROP_BACK  = 3'd3;
   localparam logic [OP_W-1:0] OP_DUMP       = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // response load request from the controller to the output register
   typedef struct packed {
      logic                load;
      logic [STATUS_W-1:0] status;
      logic                from_ram;
      logic                last;
      logic [OCC_W-1:0]    occupancy;
   } rsp_ctl_type;

endpackage

>>> src/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_ram #(
   parameter int DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [deq_pkg::VALUE_W-1:0]  wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [deq_pkg::VALUE_W-1:0]  rd_data
);
   import deq_pkg::*;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Front pointer, count and sequencer: decodes operations, drives the slot
// store and requests responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_ctrl #(
   parameter int DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [deq_pkg::OP_W-1:0]     req_op,
   input  logic [deq_pkg::VALUE_W-1:0]  req_value,
   output logic                         busy,
   output logic                         wr_en,
   output logic [$clog2(DEPTH)-1:0]     wr_addr,
   output logic [deq_pkg::VALUE_W-1:0]  wr_data,
   output logic                         rd_en,
   output logic [$clog2(DEPTH)-1:0]     rd_addr,
   output deq_pkg::rsp_ctl_type         rsp_ctl
);
   import deq_pkg::*;

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [AW:0]      DEPTH_S = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0]    TOP_IDX = AW'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_FETCH = 3'b010,
      S_DUMP  = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [AW-1:0]    front_ff, front_in;
   logic [AW-1:0]    off_ff, off_in;

   logic [AW-1:0]    off;
   logic [AW:0]      sum;
   logic [AW:0]      sum_wrap;
   logic [AW-1:0]    ring_addr;
   logic [AW-1:0]    front_dec;
   logic [AW-1:0]    front_inc;
   logic [AW-1:0]    cnt_low;
   logic             full;
   logic             empty;
   logic             dump_last;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign cnt_low = count_ff[AW-1:0];

   // offset from the front for the slot being addressed
   always_comb begin
      off = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_op == OP_PUSH_BACK) begin
               off = cnt_low;
            end else if (req_op == OP_DROP_BACK) begin
               off = cnt_low - 1'b1;
            end
         end
         S_DUMP:  off = off_ff + 1'b1;
         default: off = '0;
      endcase
   end

   assign sum       = {1'b0, front_ff} + {1'b0, off};
   assign sum_wrap  = sum - DEPTH_S;
   assign ring_addr = (sum >= DEPTH_S) ? sum_wrap[AW-1:0] : sum[AW-1:0];
   assign front_dec = (front_ff == '0) ? TOP_IDX : front_ff - 1'b1;
   assign front_inc = (front_ff == TOP_IDX) ? '0 : front_ff + 1'b1;
   assign dump_last = (CNT_W'(off_ff) == count_ff - 1'b1);

   assign rd_addr = ring_addr;
   assign wr_data = req_value;
   assign busy    = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      front_in  = front_ff;
      off_in    = off_ff;
      wr_en     = 1'b0;
      wr_addr   = ring_addr;
      rd_en     = 1'b0;
      rsp_ctl.load     = 1'b0;
      rsp_ctl.status   = ST_OK;
      rsp_ctl.from_ram = 1'b0;
      rsp_ctl.last     = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_ctl.load = 1'b1;
               case (req_op)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     if (full) begin
                        rsp_ctl.status = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                        if (req_op == OP_PUSH_FRONT) begin
                           wr_addr  = front_dec;
                           front_in = front_dec;
                        end
                     end
                  end
                  OP_DROP_FRONT, OP_DROP_BACK: begin
                     if (empty) begin
                        rsp_ctl.status = ST_EMPTY;
                     end else begin
                        // response is loaded once the slot data returns
                        rsp_ctl.load = 1'b0;
                        rd_en        = 1'b1;
                        count_in     = count_ff - 1'b1;
                        state_in     = S_FETCH;
                        if (req_op == OP_DROP_FRONT) begin
                           front_in = front_inc;
                        end
                     end
                  end
                  OP_DUMP: begin
                     if (empty) begin
                        rsp_ctl.status = ST_EMPTY;
                     end else begin
                        rsp_ctl.load = 1'b0;
                        rd_en        = 1'b1;
                        off_in       = '0;
                        state_in     = S_DUMP;
                     end
                  end
                  default: rsp_ctl.status = ST_OK;
               endcase
            end
         end
         S_FETCH: begin
            rsp_ctl.load     = 1'b1;
            rsp_ctl.from_ram = 1'b1;
            state_in         = S_IDLE;
         end
         S_DUMP: begin
            rsp_ctl.load     = 1'b1;
            rsp_ctl.from_ram = 1'b1;
            rsp_ctl.last     = dump_last;
            if (dump_last) begin
               state_in = S_IDLE;
            end else begin
               rd_en  = 1'b1;
               off_in = off_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_ctl.occupancy = OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         front_ff <= '0;
         off_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         front_ff <= front_in;
         off_ff   <= off_in;
      end
   end

endmodule

>>> src/double_ended_queue_store.sv
// ----------------------------------------------------------------------------
// double_ended_queue_store
// Bounded double-ended queue of signed 32-bit values kept in a ring store.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken on the rising edge where start is high and busy is
//   low; req_op selects push front, push back, drop front, drop back or dump,
//   and req_value carries the value for a push.
//   Each response appears on the rsp_ ports for one cycle with rsp_strobe
//   high; the receiver cannot stall it. rsp_last marks the final response of
//   a command, rsp_occupancy the stored count after it.
//   Timing:
//     push, refused push, empty drop, empty dump, unused op: response in the
//       next cycle, busy stays low, one command per cycle.
//     drop: the slot is read into the store's read register, then loaded into
//       the response register; busy is high while the read is in flight.
//     dump of N values: one store read per cycle, N responses on consecutive
//       cycles, busy high until the last response is loaded.
//   Reset clears the front pointer and count and empties the queue; the slot
//   store itself is not cleared and needs no clearing pass. Only occupied
//   slots are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue_store #(
   parameter int DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic        [deq_pkg::OP_W-1:0]     req_op,
   input  logic signed [deq_pkg::VALUE_W-1:0]  req_value,
   output logic                                rsp_strobe,
   output logic        [deq_pkg::STATUS_W-1:0] rsp_status,
   output logic signed [deq_pkg::VALUE_W-1:0]  rsp_item,
   output logic                                rsp_last,
   output logic        [deq_pkg::OCC_W-1:0]    rsp_occupancy
);
   import deq_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data;
   rsp_ctl_type        rsp_ctl;

   logic               strobe_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [VALUE_W-1:0] item_ff;
   logic               last_ff;
   logic [OCC_W-1:0]   occ_ff;

   deq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_op    (req_op),
      .req_value (req_value),
      .busy      (busy),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rsp_ctl   (rsp_ctl)
   );

   deq_ram #(.DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= rsp_ctl.load;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ctl.load) begin
         status_ff <= rsp_ctl.status;
         item_ff   <= rsp_ctl.from_ram ? rd_data : '0;
         last_ff   <= rsp_ctl.last;
         occ_ff    <= rsp_ctl.occupancy;
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_status    = status_ff;
   assign rsp_item      = item_ff;
   assign rsp_last      = last_ff;
   assign rsp_occupancy = occ_ff;

endmodule

>>> src/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks for the double-ended queue store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_checker #(
   parameter int DEPTH = 64
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_strobe,
   input logic        [deq_pkg::STATUS_W-1:0] rsp_status,
   input logic signed [deq_pkg::VALUE_W-1:0]  rsp_item,
   input logic                                rsp_last,
   input logic        [deq_pkg::OCC_W-1:0]    rsp_occupancy
);
   import deq_pkg::*;

   localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(DEPTH);

   // every command shows either a response or busy in the following cycle
   a_cmd_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("command accepted without response or busy");

   // a dump in progress keeps the block busy until its last response
   a_dump_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> busy)
      else $error("non-final response while idle");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_FULL) |-> (rsp_occupancy == DEPTH_OCC))
      else $error("full status with queue not full");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_EMPTY) |-> (rsp_occupancy == '0 && rsp_item == '0))
      else $error("empty status with stored values or nonzero item");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("activity right after reset");

endmodule

bind double_ended_queue_store deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);

>>> dv/deq_store_checker.sv
// ----------------------------------------------------------------------------
// deq_store_checker
// Watches the command and response ports of the double-ended queue store,
// keeps its own ring of stored values, and checks every response in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_store_checker #(
   parameter int DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic        [deq_pkg::OP_W-1:0]     req_op,
   input  logic signed [deq_pkg::VALUE_W-1:0]  req_value,
   input  logic                                rsp_strobe,
   input  logic        [deq_pkg::STATUS_W-1:0] rsp_status,
   input  logic signed [deq_pkg::VALUE_W-1:0]  rsp_item,
   input  logic                                rsp_last,
   input  logic        [deq_pkg::OCC_W-1:0]    rsp_occupancy,
   output int                                  fail_count,
   output int                                  rsp_waiting
);

   import deq_pkg::*;

   typedef struct {
      logic        [STATUS_W-1:0] status;
      logic signed [VALUE_W-1:0]  item;
      logic                       last;
      logic        [OCC_W-1:0]    occupancy;
   } deq_rsp_type;

   logic signed [VALUE_W-1:0] ring_slots [DEPTH];
   int                        ring_front;
   int                        ring_count;
   deq_rsp_type               pending_rsp_q [$];

   initial begin
      fail_count  = 0;
      rsp_waiting = 0;
      ring_front  = 0;
      ring_count  = 0;
   end

   function automatic void queue_rsp(input logic [STATUS_W-1:0] status,
                                     input logic signed [VALUE_W-1:0] item,
                                     input logic last);
      deq_rsp_type r;
      r.status    = status;
      r.item      = item;
      r.last      = last;
      r.occupancy = OCC_W'(ring_count);
      pending_rsp_q.push_back(r);
   endfunction

   // work out the responses of one accepted transaction and update the ring
   function automatic void apply_deque_op(input logic [OP_W-1:0] op,
                                          input logic signed [VALUE_W-1:0] value);
      logic signed [VALUE_W-1:0] removed;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (ring_count >= DEPTH) begin
               queue_rsp(ST_FULL, '0, 1'b1);
            end else begin
               if (op == OP_PUSH_FRONT) begin
                  ring_front = (ring_front + DEPTH - 1) % DEPTH;
                  ring_slots[ring_front] = value;
               end else begin
                  ring_slots[(ring_front + ring_count) % DEPTH] = value;
               end
               ring_count++;
               queue_rsp(ST_OK, '0, 1'b1);
            end
         end
         OP_DROP_FRONT, OP_DROP_BACK: begin
            if (ring_count == 0) begin
               queue_rsp(ST_EMPTY, '0, 1'b1);
            end else begin
               if (op == OP_DROP_FRONT) begin
                  removed    = ring_slots[ring_front];
                  ring_front = (ring_front + 1) % DEPTH;
               end else begin
                  removed = ring_slots[(ring_front + ring_count - 1) % DEPTH];
               end
               ring_count--;
               queue_rsp(ST_OK, removed, 1'b1);
            end
         end
         OP_DUMP: begin
            if (ring_count == 0)
               queue_rsp(ST_EMPTY, '0, 1'b1);
            else
               for (int i = 0; i < ring_count; i++)
                  queue_rsp(ST_OK, ring_slots[(ring_front + i) % DEPTH],
                            i == ring_count - 1);
         end
         default: queue_rsp(ST_OK, '0, 1'b1);   // unused codes change nothing
      endcase
   endfunction

   task automatic check_field(input string name,
                              input logic signed [VALUE_W-1:0] want,
                              input logic signed [VALUE_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      deq_rsp_type want;
      if (reset) begin
         ring_front = 0;
         ring_count = 0;
         pending_rsp_q.delete();
      end else begin
         // responses first: none can belong to a transaction taken this edge
         if (rsp_strobe === 1'b1) begin
            if (pending_rsp_q.size() == 0) begin
               $error("unexpected response: status %0d item %0d last %0d occupancy %0d",
                      rsp_status, rsp_item, rsp_last, rsp_occupancy);
               fail_count++;
            end else begin
               want = pending_rsp_q.pop_front();
               check_field("rsp_status", VALUE_W'(want.status), VALUE_W'(rsp_status));
               check_field("rsp_item", want.item, rsp_item);
               check_field("rsp_last", VALUE_W'(want.last), VALUE_W'(rsp_last));
               check_field("rsp_occupancy", VALUE_W'(want.occupancy),
                           VALUE_W'(rsp_occupancy));
            end
         end
         if (start && !busy)
            apply_deque_op(req_op, req_value);
      end
      rsp_waiting = pending_rsp_q.size();
   end

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for double_ended_queue_store: directed corner transactions, then
// random fill, mixed and drain phases with random gaps; a checker compares
// every response against its own ring model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   import deq_pkg::*;

   localparam int DEPTH        = 64;
   localparam int NUM_ITEMS    = 400;
   localparam int DRAIN_CYCLES = DEPTH + 8;
   localparam int CYCLE_LIMIT  = 200000;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic        [OP_W-1:0]     req_op;
   logic signed [VALUE_W-1:0]  req_value;
   logic                       rsp_strobe;
   logic        [STATUS_W-1:0] rsp_status;
   logic signed [VALUE_W-1:0]  rsp_item;
   logic                       rsp_last;
   logic        [OCC_W-1:0]    rsp_occupancy;

   int   fail_count;
   int   rsp_waiting;
   int   cycle_count = 0;
   int   items_sent  = 0;
   int   idle_pct    = 16;
   logic took        = 1'b0;

   double_ended_queue_store #(.DEPTH(DEPTH)) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_item      (rsp_item),
      .rsp_last      (rsp_last),
      .rsp_occupancy (rsp_occupancy)
   );

   deq_store_checker #(.DEPTH(DEPTH)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_item      (rsp_item),
      .rsp_last      (rsp_last),
      .rsp_occupancy (rsp_occupancy),
      .fail_count    (fail_count),
      .rsp_waiting   (rsp_waiting)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // transaction taken at this edge; read back at the following falling edge
   always @(posedge clock) begin
      took <= start && !busy;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_cmd(input logic [OP_W-1:0] op,
                           input logic signed [VALUE_W-1:0] value);
      // each cycle idles with probability idle_pct
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start     = 1'b1;
      req_op    = op;
      req_value = value;
      do @(negedge clock); while (!took);
      items_sent++;
   endtask

   task automatic wait_drained();
      start = 1'b0;
      while (rsp_waiting != 0) @(negedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] rand_value();
      case ($urandom_range(9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_op(input int push_pct, input int drop_pct);
      int r;
      r = $urandom_range(99);
      if (r < push_pct)
         return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      if (r < push_pct + drop_pct)
         return $urandom_range(1) ? OP_DROP_BACK : OP_DROP_FRONT;
      if (r < 97)
         return OP_DUMP;
      return OP_W'($urandom_range(7, 5));   // unused codes
   endfunction

   initial begin : stimulus
      int phase_num;
      int len;
      int push_pct;
      int drop_pct;

      reset     = 1'b1;
      start     = 1'b0;
      req_op    = OP_PUSH_FRONT;
      req_value = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty queue corners
      send_cmd(OP_DROP_FRONT, rand_value());
      send_cmd(OP_DROP_BACK, rand_value());
      send_cmd(OP_DUMP, rand_value());
      // value extremes at both ends
      send_cmd(OP_PUSH_FRONT, 32'sh8000_0000);
      send_cmd(OP_PUSH_BACK, 32'sh7fff_ffff);
      send_cmd(OP_PUSH_FRONT, '0);
      send_cmd(OP_PUSH_BACK, '1);
      send_cmd(OP_PUSH_FRONT, 32'sh5555_5555);
      send_cmd(OP_PUSH_BACK, 32'shaaaa_aaaa);
      send_cmd(OP_DUMP, rand_value());
      for (int c = 5; c <= 7; c++)
         send_cmd(OP_W'(c), rand_value());
      send_cmd(OP_DROP_FRONT, rand_value());
      send_cmd(OP_DROP_BACK, rand_value());
      send_cmd(OP_DUMP, rand_value());
      repeat (2) begin
         send_cmd(OP_DROP_FRONT, rand_value());
         send_cmd(OP_DROP_BACK, rand_value());
      end
      send_cmd(OP_DROP_FRONT, rand_value());
      send_cmd(OP_DUMP, rand_value());
      wait_drained();

      // phases cycle fill / mixed / drain; the first fill is long enough to
      // hit the full queue, and the first drain runs with no gaps
      phase_num = 0;
      while (items_sent < NUM_ITEMS) begin
         case (phase_num % 3)
            0: begin push_pct = 88; drop_pct = 6;  end
            1: begin push_pct = 45; drop_pct = 45; end
            default: begin push_pct = 6; drop_pct = 88; end
         endcase
         len      = (phase_num == 0) ? 100 : $urandom_range(90, 30);
         idle_pct = (phase_num == 2) ? 0 : 16;
         repeat (len) send_cmd(pick_op(push_pct, drop_pct), rand_value());
         if (phase_num % 2 == 1)
            wait_drained();
         phase_num++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> filelist.f
src/deq_pkg.sv
src/deq_ram.sv
src/deq_ctrl.sv
src/double_ended_queue_store.sv
src/deq_checker.sv
dv/deq_store_checker.sv
dv/tb.sv
